FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define D3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define D3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dist3_pkg.sv
// Package: widths, pipeline depth and the square-root cell payload type.
package dist3_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned ROOT_W    = SQ_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 3;
  localparam int unsigned DIST_W    = 31;
  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned LATENCY   = FRONT_LAT + ROOT_W + 1;
  localparam int unsigned CNT_W     = $clog2(LATENCY + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // one item as it moves along the root cells
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
    logic              scale;
  } cell_data_t;

endpackage

FILE: rtl/dist3_front.sv
// Front end: axis differences, range scaling, squares and the sum of squares.
module dist3_front import dist3_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    valid_i,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] az,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  input  logic signed [COORD_W-1:0] bz,
  output logic                    valid_o,
  output cell_data_t              d_o
);

  logic [DIFF_W-1:0] dx, dy, dz;
  logic              big;
  logic [MAG_W-1:0]  vx, vy, vz;
  logic [MAG_W-1:0]  mx_nxt, my_nxt, mz_nxt;

  logic [FRONT_LAT-1:0] vld_r;
  logic [MAG_W-1:0]     mx_r, my_r, mz_r;
  logic [SQ_W-1:0]      px_r, py_r, pz_r, pz2_r, sxy_r, sum_r;
  logic [FRONT_LAT-1:0] sc_r;

  function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  always_comb begin
    dx  = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    dy  = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    dz  = {az[COORD_W-1], az} - {bz[COORD_W-1], bz};
    // a difference outside the 32-bit range has its top two bits unequal
    big = (dx[DIFF_W-1] ^ dx[DIFF_W-2]) | (dy[DIFF_W-1] ^ dy[DIFF_W-2]) |
          (dz[DIFF_W-1] ^ dz[DIFF_W-2]);
    vx  = big ? dx[DIFF_W-1:1] : dx[MAG_W-1:0];
    vy  = big ? dy[DIFF_W-1:1] : dy[MAG_W-1:0];
    vz  = big ? dz[DIFF_W-1:1] : dz[MAG_W-1:0];
    mx_nxt = mag(vx);
    my_nxt = mag(vy);
    mz_nxt = mag(vz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[FRONT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      mz_r  <= mz_nxt;
      px_r  <= SQ_W'(mx_r) * SQ_W'(mx_r);
      py_r  <= SQ_W'(my_r) * SQ_W'(my_r);
      pz_r  <= SQ_W'(mz_r) * SQ_W'(mz_r);
      sxy_r <= px_r + py_r;
      pz2_r <= pz_r;
      sum_r <= sxy_r + pz2_r;
      sc_r  <= {sc_r[FRONT_LAT-2:0], big};
    end
  end

  assign valid_o  = vld_r[FRONT_LAT-1];
  assign d_o.rem   = '0;
  assign d_o.root  = '0;
  assign d_o.rad   = sum_r;
  assign d_o.scale = sc_r[FRONT_LAT-1];

endmodule

FILE: rtl/dist3_cell.sv
// Square-root cell: settles one root bit, hands the partial result onward.
module dist3_cell import dist3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       valid_i,
  input  cell_data_t d_i,
  output logic       valid_o,
  output cell_data_t d_o
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  cell_data_t       d_nxt;
  logic             valid_r;
  cell_data_t       d_r;

  always_comb begin
    // remainder stays below 2^33, so its top bits can be dropped
    rem_sh = {d_i.rem[REM_W-3:0], d_i.rad[SQ_W-1 -: 2]};
    trial  = {1'b0, d_i.root, 2'b01};
    ge     = (rem_sh >= trial);
    d_nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
    d_nxt.root  = {d_i.root[ROOT_W-2:0], ge};
    d_nxt.rad   = {d_i.rad[SQ_W-3:0], 2'b00};
    d_nxt.scale = d_i.scale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;

endmodule

FILE: rtl/distance_3d_integer_top.sv
// Top level: truncated 3D Euclidean distance between two integer points.
// Pipeline: 4 front stages, 32 root cells and 1 output register between
//   input accept and result valid.
// Throughput: one item per cycle; the whole pipe holds only while a result
//   waits at the output and the output is stalled.
// Reset: synchronous, active low; clears every valid bit, data regs keep junk.
module distance_3d_integer_top import dist3_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_first_z,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_second_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DIST_W-1:0]         out_distance
);

  // Pipe moves whenever the output register is empty or being drained.
  logic adv;

  // Chain: index 0 is the front end output, index k the output of cell k-1.
  logic       vld   [ROOT_W+1];
  cell_data_t dat   [ROOT_W+1];

  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] dist_nxt;
  logic [ROOT_W-1:0] root;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Differences, scaling, squares and sum of squares.
  dist3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_valid),
    .ax      (in_first_x),
    .ay      (in_first_y),
    .az      (in_first_z),
    .bx      (in_second_x),
    .by      (in_second_y),
    .bz      (in_second_z),
    .valid_o (vld[0]),
    .d_o     (dat[0])
  );

  // Row of root cells, one result bit each, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    dist3_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (vld[k]),
      .d_i     (dat[k]),
      .valid_o (vld[k+1]),
      .d_o     (dat[k+1])
    );
  end

  // Undo the range scaling and saturate at the largest positive value.
  always_comb begin
    root = dat[ROOT_W].root;
    if (dat[ROOT_W].scale) begin
      dist_nxt = (root[ROOT_W-1:DIST_W-1] != '0) ? DIST_MAX
                                                  : {root[DIST_W-2:0], 1'b0};
    end else begin
      dist_nxt = root[ROOT_W-1] ? DIST_MAX : root[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;

endmodule

FILE: rtl/dist3_checker.sv
// Port-level checker for the distance block, bound to the top level.
`include "assert_macros.svh"

module dist3_checker import dist3_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  logic [CNT_W-1:0] cnt_r;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  `D3_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `D3_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without cause")
  `D3_ASSERT(a_no_phantom, out_valid |-> cnt_r != '0, "result with no item in flight")
  `D3_ASSERT(a_depth, cnt_r <= CNT_W'(LATENCY), "more items in flight than stages")

endmodule

bind distance_3d_integer_top dist3_checker u_dist3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
